// File: rtl/gcc_pkg.sv
package gcc_pkg;

    localparam int WEIGHT_FRACTION_BITS = 16;

    localparam int ALT_W       = 15;
    localparam int SLOPE_W     = 15;
    localparam int CHAN_W      = 8;
    localparam int COL_W       = 16;
    localparam int NUM_W       = 12;
    localparam int DIFF_W      = 17;
    localparam int RECIP_SHIFT = NUM_W;
    localparam int N_CH        = 3;
    localparam int N_RAMP      = 6;
    localparam int N_MIX       = 5;
    localparam int RAMP_STAGES = 5;

    // ramp lanes
    localparam int R_FOREST     = 0;
    localparam int R_ALPINE     = 1;
    localparam int R_ROCK_SLOPE = 2;
    localparam int R_ROCK_ALT   = 3;
    localparam int R_SNOW_ALT   = 4;
    localparam int R_STEEP      = 5;

    // slope thresholds are degrees * 256
    localparam int RAMP_LOW [N_RAMP] = '{1536, 1700, 8704, 2250, 2500, 9728};
    localparam int RAMP_DEN [N_RAMP] = '{2048, 300, 2560, 200, 200, 3072};
    localparam logic [N_RAMP-1:0] RAMP_ON_SLOPE = 6'b100101;

    typedef struct packed {
        logic signed [ALT_W-1:0] altitude;
        logic [SLOPE_W-1:0]      slope;
    } sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } cover_t;

    typedef logic [COL_W-1:0] chan_t;
    typedef chan_t [0:N_CH-1] colour_t;

    // palette in Q8.8
    localparam colour_t PAL_MEADOW = '{16'd23552, 16'd28160, 16'd14336};
    localparam colour_t PAL_FOREST = '{16'd11264, 16'd15872, 16'd9216};
    localparam colour_t PAL_ALPINE = '{16'd28672, 16'd28672, 16'd18944};
    localparam colour_t PAL_ROCK   = '{16'd30208, 16'd29184, 16'd27136};
    localparam colour_t PAL_SNOW   = '{16'd59392, 16'd60416, 16'd61440};

    localparam colour_t MIX_TARGET [N_MIX] =
        '{PAL_FOREST, PAL_ALPINE, PAL_ROCK, PAL_ROCK, PAL_SNOW};

endpackage

// File: rtl/gcc_ramps.sv
module gcc_ramps #(
    parameter int F = gcc_pkg::WEIGHT_FRACTION_BITS
) (
    input  logic                                clk,
    input  gcc_pkg::sample_t                    sample,
    input  logic [gcc_pkg::RAMP_STAGES-1:0]     en,
    output logic [F:0]                          weight [gcc_pkg::N_RAMP]
);

    localparam int W   = F + 1;
    localparam int QW  = F;
    localparam int RW  = F + 5;
    localparam int PW  = gcc_pkg::NUM_W + RW;
    localparam int SW  = F + gcc_pkg::NUM_W;
    localparam int T2W = 2 * F + 2;
    localparam int MW  = F + 2;
    localparam int SFW = 2 * F + 3;
    localparam int SHW = F + 3;
    localparam logic [W-1:0]  ONE   = {1'b1, {F{1'b0}}};
    localparam logic [MW-1:0] THREE = MW'(3) << F;

    for (genvar i = 0; i < gcc_pkg::N_RAMP; i++) begin : g_lane
        localparam bit ON_SLOPE = gcc_pkg::RAMP_ON_SLOPE[i];
        localparam longint unsigned RECIP =
            (64'd1 << (F + gcc_pkg::RECIP_SHIFT)) / longint'(gcc_pkg::RAMP_DEN[i]);
        localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
        localparam logic signed [gcc_pkg::DIFF_W-1:0] LOW =
            gcc_pkg::DIFF_W'(gcc_pkg::RAMP_LOW[i]);
        localparam logic [gcc_pkg::DIFF_W-2:0] DEN_U =
            (gcc_pkg::DIFF_W-1)'(gcc_pkg::RAMP_DEN[i]);
        localparam logic [gcc_pkg::NUM_W-1:0] DEN = gcc_pkg::NUM_W'(gcc_pkg::RAMP_DEN[i]);

        logic signed [gcc_pkg::DIFF_W-1:0] value;
        logic signed [gcc_pkg::DIFF_W-1:0] num;
        logic                              zero_next;
        logic                              one_next;
        logic [PW-1:0]                     prod;
        logic [SW-1:0]                     rem;
        logic [W-1:0]                      t_next;
        logic [T2W-1:0]                    tsq;
        logic [MW-1:0]                     m;
        logic [SFW-1:0]                    sfull;
        logic [SHW-1:0]                    sh;
        logic [W-1:0]                      s_next;

        logic [gcc_pkg::NUM_W-1:0] s1_num_reg;
        logic                      s1_zero_reg;
        logic                      s1_one_reg;
        logic [QW-1:0]             s2_q_reg;
        logic [gcc_pkg::NUM_W-1:0] s2_num_reg;
        logic                      s2_zero_reg;
        logic                      s2_one_reg;
        logic [W-1:0]              s3_t_reg;
        logic [W-1:0]              s4_t_reg;
        logic [W-1:0]              s4_t2_reg;
        logic [W-1:0]              s5_s_reg;

        always_comb
        begin
            if (ON_SLOPE)
            begin
                value = signed'({2'b00, sample.slope});
            end
            else
            begin
                value = {{(gcc_pkg::DIFF_W - gcc_pkg::ALT_W){sample.altitude[gcc_pkg::ALT_W-1]}},
                         sample.altitude};
            end
            num       = value - LOW;
            zero_next = num[gcc_pkg::DIFF_W-1] || (num == '0);
            one_next  = !num[gcc_pkg::DIFF_W-1] && (num[gcc_pkg::DIFF_W-2:0] >= DEN_U);
        end

        // quotient estimate by reciprocal, low by at most one
        assign prod = PW'(s1_num_reg) * PW'(RECIP_C);

        always_comb
        begin
            rem = {s2_num_reg, {F{1'b0}}} - SW'(s2_q_reg) * SW'(DEN);
            if (s2_zero_reg)
            begin
                t_next = '0;
            end
            else if (s2_one_reg)
            begin
                t_next = ONE;
            end
            else if (rem >= SW'(DEN))
            begin
                t_next = W'(s2_q_reg) + W'(1);
            end
            else
            begin
                t_next = W'(s2_q_reg);
            end
        end

        assign tsq = T2W'(s3_t_reg) * T2W'(s3_t_reg);

        // smoothstep t2 * (3 - 2t)
        always_comb
        begin
            m     = THREE - (MW'(s4_t_reg) << 1);
            sfull = SFW'(s4_t2_reg) * SFW'(m);
            sh    = sfull[SFW-1:F];
            if (sh > SHW'(ONE))
            begin
                s_next = ONE;
            end
            else
            begin
                s_next = sh[W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                s1_num_reg  <= num[gcc_pkg::NUM_W-1:0];
                s1_zero_reg <= zero_next;
                s1_one_reg  <= one_next;
            end
            if (en[1])
            begin
                s2_q_reg    <= prod[gcc_pkg::RECIP_SHIFT+QW-1:gcc_pkg::RECIP_SHIFT];
                s2_num_reg  <= s1_num_reg;
                s2_zero_reg <= s1_zero_reg;
                s2_one_reg  <= s1_one_reg;
            end
            if (en[2])
            begin
                s3_t_reg <= t_next;
            end
            if (en[3])
            begin
                s4_t_reg  <= s3_t_reg;
                s4_t2_reg <= tsq[2*F:F];
            end
            if (en[4])
            begin
                s5_s_reg <= s_next;
            end
        end

        assign weight[i] = s5_s_reg;
    end

endmodule

// File: rtl/gcc_mix.sv
module gcc_mix #(
    parameter int F = gcc_pkg::WEIGHT_FRACTION_BITS
) (
    input  logic                      clk,
    input  logic                      en,
    input  gcc_pkg::colour_t          prev_col,
    input  gcc_pkg::colour_t          prev_step,
    input  logic [gcc_pkg::N_CH-1:0]  prev_down,
    input  gcc_pkg::colour_t          target,
    input  logic [F:0]                weight,
    output gcc_pkg::colour_t          col,
    output gcc_pkg::colour_t          step,
    output logic [gcc_pkg::N_CH-1:0]  down
);

    localparam int PW = gcc_pkg::COL_W + F + 1;

    gcc_pkg::colour_t          cur;
    gcc_pkg::colour_t          diff;
    gcc_pkg::colour_t          step_next;
    logic [gcc_pkg::N_CH-1:0]  down_next;
    logic [PW-1:0]             prod [gcc_pkg::N_CH];

    gcc_pkg::colour_t          col_reg;
    gcc_pkg::colour_t          step_reg;
    logic [gcc_pkg::N_CH-1:0]  down_reg;

    // finish the previous blend, then scale the distance to the next target
    always_comb
    begin
        for (int c = 0; c < gcc_pkg::N_CH; c++)
        begin
            cur[c]       = prev_down[c] ? prev_col[c] - prev_step[c]
                                        : prev_col[c] + prev_step[c];
            down_next[c] = target[c] < cur[c];
            diff[c]      = down_next[c] ? cur[c] - target[c] : target[c] - cur[c];
            prod[c]      = PW'(diff[c]) * PW'(weight);
            step_next[c] = prod[c][gcc_pkg::COL_W+F-1:F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg  <= cur;
            step_reg <= step_next;
            down_reg <= down_next;
        end
    end

    assign col  = col_reg;
    assign step = step_reg;
    assign down = down_reg;

endmodule

// File: rtl/ground_cover_colour_core.sv
// Ground-cover colour: one terrain sample (altitude in metres, slope in 1/256 degree) in, one
// RGB colour out. The block is fully pipelined and takes one sample per clock while the
// output is not stalled. Five stages form the six smoothstep ramps in parallel (ramp divide
// by a constant reciprocal multiply with one correction, then the two smoothstep products),
// five stages apply the chained blends meadow, forest, alpine, rock, rock, snow (one blend
// multiply per stage), and the last stage rounds down to 8-bit channels. Each stage holds
// its item while the one after it is full and stalled, so bubbles close up and a new sample
// is taken whenever any stage is free.
module ground_cover_colour_core #(
    parameter int WEIGHT_FRACTION_BITS = gcc_pkg::WEIGHT_FRACTION_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  gcc_pkg::sample_t sample,
    output logic             colour_valid,
    input  logic             colour_stall,
    output gcc_pkg::cover_t  colour
);

    localparam int F      = WEIGHT_FRACTION_BITS;
    localparam int W      = F + 1;
    localparam int NMIX   = gcc_pkg::N_MIX;
    localparam int MIX0   = gcc_pkg::RAMP_STAGES;
    localparam int NSTAGE = gcc_pkg::RAMP_STAGES + NMIX + 1;
    localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] ready;

    logic [W-1:0]      w_ramp [gcc_pkg::N_RAMP];
    logic [2*W-1:0]    snow_prod;
    logic [W-1:0]      w_snow;
    logic [W-1:0]      wd_reg [NMIX-1][NMIX-1];

    gcc_pkg::colour_t          mix_col  [NMIX];
    gcc_pkg::colour_t          mix_step [NMIX];
    logic [gcc_pkg::N_CH-1:0]  mix_down [NMIX];
    gcc_pkg::colour_t          final_col;
    gcc_pkg::cover_t           colour_reg;

    // a stage may load when it or any later stage is empty, or the output is taken
    for (genvar k = 0; k < NSTAGE; k++) begin : g_ready
        assign ready[k] = !colour_stall || !(&valid_reg[NSTAGE-1:k]);
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? sample_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_stall = !ready[0];
    assign colour_valid = valid_reg[NSTAGE-1];

    gcc_ramps #(
        .F(F)
    ) u_ramps (
        .clk    (clk),
        .sample (sample),
        .en     (ready[gcc_pkg::RAMP_STAGES-1:0]),
        .weight (w_ramp)
    );

    // snow fades out on steep ground
    assign snow_prod = (2*W)'(w_ramp[gcc_pkg::R_SNOW_ALT])
                     * (2*W)'(ONE - w_ramp[gcc_pkg::R_STEEP]);
    assign w_snow    = snow_prod[2*F:F];

    // weights for the later blends ride along with the item
    always_ff @(posedge clk)
    begin
        if (ready[MIX0])
        begin
            wd_reg[0][0] <= w_ramp[gcc_pkg::R_ALPINE];
            wd_reg[0][1] <= w_ramp[gcc_pkg::R_ROCK_SLOPE];
            wd_reg[0][2] <= w_ramp[gcc_pkg::R_ROCK_ALT];
            wd_reg[0][3] <= w_snow;
        end
        for (int r = 1; r < NMIX - 1; r++)
        begin
            if (ready[MIX0+r])
            begin
                wd_reg[r] <= wd_reg[r-1];
            end
        end
    end

    for (genvar m = 0; m < NMIX; m++) begin : g_mix
        if (m == 0) begin : g_first
            gcc_mix #(
                .F(F)
            ) u_mix (
                .clk       (clk),
                .en        (ready[MIX0]),
                .prev_col  (gcc_pkg::PAL_MEADOW),
                .prev_step ('0),
                .prev_down ('0),
                .target    (gcc_pkg::MIX_TARGET[0]),
                .weight    (w_ramp[gcc_pkg::R_FOREST]),
                .col       (mix_col[0]),
                .step      (mix_step[0]),
                .down      (mix_down[0])
            );
        end
        else begin : g_next
            gcc_mix #(
                .F(F)
            ) u_mix (
                .clk       (clk),
                .en        (ready[MIX0+m]),
                .prev_col  (mix_col[m-1]),
                .prev_step (mix_step[m-1]),
                .prev_down (mix_down[m-1]),
                .target    (gcc_pkg::MIX_TARGET[m]),
                .weight    (wd_reg[m-1][m-1]),
                .col       (mix_col[m]),
                .step      (mix_step[m]),
                .down      (mix_down[m])
            );
        end
    end

    // blends stay inside the palette, so the integer part never leaves 0..255
    always_comb
    begin
        for (int c = 0; c < gcc_pkg::N_CH; c++)
        begin
            final_col[c] = mix_down[NMIX-1][c] ? mix_col[NMIX-1][c] - mix_step[NMIX-1][c]
                                               : mix_col[NMIX-1][c] + mix_step[NMIX-1][c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[NSTAGE-1])
        begin
            colour_reg.red   <= final_col[0][gcc_pkg::COL_W-1:gcc_pkg::COL_W-gcc_pkg::CHAN_W];
            colour_reg.green <= final_col[1][gcc_pkg::COL_W-1:gcc_pkg::COL_W-gcc_pkg::CHAN_W];
            colour_reg.blue  <= final_col[2][gcc_pkg::COL_W-1:gcc_pkg::COL_W-gcc_pkg::CHAN_W];
        end
    end

    assign colour = colour_reg;

`ifndef ASSERT_OFF
    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> $countones(valid_reg) == $past($countones(valid_reg))
            + $past(int'(sample_valid && !sample_stall))
            - $past(int'(colour_valid && !colour_stall)))
        else $error("pipeline lost or invented an item");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> !sample_stall)
        else $error("request stalled with first stage empty");

    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[gcc_pkg::RAMP_STAGES-1] |->
            w_ramp[0] <= ONE && w_ramp[1] <= ONE && w_ramp[2] <= ONE &&
            w_ramp[3] <= ONE && w_ramp[4] <= ONE && w_ramp[5] <= ONE)
        else $error("ramp weight above one");

    a_snow_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[MIX0] |-> wd_reg[0][3] <= ONE)
        else $error("snow weight above one");
`endif

endmodule

// File: dv/cover_colour_checker.sv
`timescale 1ns / 1ps

module cover_colour_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    input  logic             sample_stall,
    input  gcc_pkg::sample_t sample,
    input  logic             colour_valid,
    input  logic             colour_stall,
    input  gcc_pkg::cover_t  colour,
    output int               pending,
    output int               failures
);

    typedef longint unsigned u64_t;

    typedef struct packed {
        int r;
        int g;
        int b;
    } shade_t;

    localparam int   FRAC = gcc_pkg::WEIGHT_FRACTION_BITS;
    localparam u64_t UNIT = u64_t'(1) << FRAC;

    // palette in Q8.8
    localparam shade_t MEADOW = '{92 * 256, 110 * 256, 56 * 256};
    localparam shade_t FOREST = '{44 * 256, 62 * 256, 36 * 256};
    localparam shade_t ALPINE = '{112 * 256, 112 * 256, 74 * 256};
    localparam shade_t ROCK   = '{118 * 256, 114 * 256, 106 * 256};
    localparam shade_t SNOW   = '{232 * 256, 236 * 256, 240 * 256};

    gcc_pkg::cover_t expected_covers[$];
    gcc_pkg::cover_t wanted;
    int              mismatch_count;

    assign failures = mismatch_count;

    function automatic u64_t smooth_weight(int value, int lo, int hi);
        longint num;
        longint den;
        u64_t   t;
        u64_t   t2;
        u64_t   s;
        num = longint'(value) - longint'(lo);
        den = longint'(hi) - longint'(lo);
        if (num <= 0)
            t = 0;
        else if (num >= den)
            t = UNIT;
        else
            t = (u64_t'(num) << FRAC) / u64_t'(den);
        t2 = (t * t) >> FRAC;
        s = (t2 * (3 * UNIT - 2 * t)) >> FRAC;
        if (s > UNIT)
            s = UNIT;
        return s;
    endfunction

    // difference scaled by the weight, truncated toward zero
    function automatic int mix_channel(int a, int b, u64_t w);
        if (b >= a)
            return a + int'((u64_t'(b - a) * w) >> FRAC);
        else
            return a - int'((u64_t'(a - b) * w) >> FRAC);
    endfunction

    function automatic shade_t mix_shade(shade_t c, shade_t target, u64_t w);
        shade_t m;
        m.r = mix_channel(c.r, target.r, w);
        m.g = mix_channel(c.g, target.g, w);
        m.b = mix_channel(c.b, target.b, w);
        return m;
    endfunction

    function automatic logic [gcc_pkg::CHAN_W-1:0] to_channel(int v);
        int ch;
        ch = (v < 0) ? 0 : (v >>> 8);
        if (ch > 255)
            ch = 255;
        return ch[gcc_pkg::CHAN_W-1:0];
    endfunction

    function automatic gcc_pkg::cover_t predict_cover(gcc_pkg::sample_t s);
        int              alt;
        int              slp;
        u64_t            w_snow;
        shade_t          c;
        gcc_pkg::cover_t res;
        alt = $signed(s.altitude);
        slp = int'(s.slope);
        c = MEADOW;
        c = mix_shade(c, FOREST, smooth_weight(slp, 6 * 256, 14 * 256));
        c = mix_shade(c, ALPINE, smooth_weight(alt, 1700, 2000));
        c = mix_shade(c, ROCK, smooth_weight(slp, 34 * 256, 44 * 256));
        c = mix_shade(c, ROCK, smooth_weight(alt, 2250, 2450));
        // snow fades out on steep ground
        w_snow = (smooth_weight(alt, 2500, 2700)
                  * (UNIT - smooth_weight(slp, 38 * 256, 50 * 256))) >> FRAC;
        c = mix_shade(c, SNOW, w_snow);
        res.red   = to_channel(c.r);
        res.green = to_channel(c.g);
        res.blue  = to_channel(c.b);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    initial
    begin
        mismatch_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_covers.delete();
            pending <= 0;
        end
        else
        begin
            if (colour_valid && !colour_stall)
            begin
                if (expected_covers.size() == 0)
                begin
                    report_mismatch($sformatf("colour %0d/%0d/%0d with no request pending",
                                              colour.red, colour.green, colour.blue));
                end
                else
                begin
                    wanted = expected_covers.pop_front();
                    if (colour.red !== wanted.red || colour.green !== wanted.green
                        || colour.blue !== wanted.blue)
                        report_mismatch($sformatf("got r=%0d g=%0d b=%0d want r=%0d g=%0d b=%0d",
                                                  colour.red, colour.green, colour.blue,
                                                  wanted.red, wanted.green, wanted.blue));
                end
            end
            if (sample_valid && !sample_stall)
                expected_covers.push_back(predict_cover(sample));
            pending <= expected_covers.size();
        end
    end

endmodule

// File: dv/ground_cover_colour_core_tb.sv
`timescale 1ns / 1ps

module ground_cover_colour_core_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_COUNT  = 850;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 30;

    logic             clk;
    logic             rst_n;
    logic             sample_valid;
    logic             sample_stall;
    gcc_pkg::sample_t sample;
    logic             colour_valid;
    logic             colour_stall;
    gcc_pkg::cover_t  colour;

    logic    rx_stall;
    logic    hold_stall;
    int      pending;
    int      failures;
    int      sent_count;
    int      cycle_count;
    bit      tx_quiet;
    bit      rx_quiet;

    assign colour_stall = rx_stall | hold_stall;

    ground_cover_colour_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .colour_valid (colour_valid),
        .colour_stall (colour_stall),
        .colour       (colour)
    );

    cover_colour_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .colour_valid (colour_valid),
        .colour_stall (colour_stall),
        .colour       (colour),
        .pending      (pending),
        .failures     (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic gcc_pkg::sample_t terrain(int alt, int slp);
        gcc_pkg::sample_t s;
        s.altitude = alt[gcc_pkg::ALT_W-1:0];
        s.slope    = slp[gcc_pkg::SLOPE_W-1:0];
        return s;
    endfunction

    // mostly near the ramp edges, some anywhere in range, some raw bits
    function automatic gcc_pkg::sample_t random_terrain();
        int alt;
        int slp;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return terrain($urandom, $urandom);
        if (pick < 35)
            return terrain($urandom_range(0, 10000) - 1000, $urandom_range(0, 23040));
        case ($urandom_range(0, 5))
            0: alt = 1700;
            1: alt = 2000;
            2: alt = 2250;
            3: alt = 2450;
            4: alt = 2500;
            default: alt = 2700;
        endcase
        case ($urandom_range(0, 5))
            0: slp = 1536;
            1: slp = 3584;
            2: slp = 8704;
            3: slp = 11264;
            4: slp = 9728;
            default: slp = 12800;
        endcase
        alt = alt + $urandom_range(0, 600) - 300;
        slp = slp + $urandom_range(0, 1536) - 768;
        return terrain(alt, slp);
    endfunction

    task automatic send_sample(input gcc_pkg::sample_t s);
        int gap;
        if (sent_count % 50 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        sent_count++;
    endtask

    // receiver: random stall before each colour
    initial
    begin : receiver
        int n;
        int taken;
        rx_stall <= 1'b0;
        taken = 0;
        rx_quiet = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 40 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            n = rx_quiet ? 0 : $urandom_range(0, 12);
            if (n > 0)
            begin
                rx_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rx_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(colour_valid && !colour_stall));
            taken++;
        end
    end

    // long hold-off so the pipeline fills and backs up into the input
    initial
    begin
        hold_stall <= 1'b0;
        wait (sent_count >= HOLD_AT);
        @(posedge clk);
        hold_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_stall <= 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        sent_count   = 0;
        tx_quiet     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, including out-of-range samples that saturate the ramps
        send_sample(terrain(-16384, 0));
        send_sample(terrain(16383, 32767));
        send_sample(terrain(-1000, 23040));
        send_sample(terrain(9000, 0));
        send_sample(terrain(0, 32767));
        send_sample(terrain(-1, 1));
        // ramp edges and midpoints
        send_sample(terrain(1700, 1536));
        send_sample(terrain(1850, 2560));
        send_sample(terrain(2000, 3584));
        send_sample(terrain(2250, 8704));
        send_sample(terrain(2350, 9984));
        send_sample(terrain(2450, 11264));
        send_sample(terrain(2500, 9728));
        send_sample(terrain(2600, 11264));
        send_sample(terrain(2700, 12800));
        send_sample(terrain(2701, 12801));
        send_sample(terrain(1701, 1537));
        send_sample(terrain(8999, 12799));
        // snow on flat ground and on cliffs
        send_sample(terrain(3000, 0));
        send_sample(terrain(3000, 23040));
        send_sample(terrain(3000, 11000));
        send_sample(terrain(2600, 5000));

        repeat (RANDOM_COUNT) send_sample(random_terrain());
        sample_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: ground_cover_colour_core.f
rtl/gcc_pkg.sv
rtl/gcc_ramps.sv
rtl/gcc_mix.sv
rtl/ground_cover_colour_core.sv
dv/cover_colour_checker.sv
dv/ground_cover_colour_core_tb.sv
